// ===== design/lru_pkg.sv =====
`default_nettype none

package lru_pkg;

	localparam int PAGE_ID_W     = 16;
	localparam int SLOT_W        = 2;
	localparam int TOTAL_W       = 32;
	localparam int WAYS_DEF      = 4;
	localparam int PAGE_BITS_DEF = 16;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [PAGE_ID_W-1:0] page_id;
		logic                 last_in_sequence;
	} in_item_t;

	typedef struct packed {
		logic                 hit;
		logic [SLOT_W-1:0]    slot;
		logic [TOTAL_W-1:0]   hit_total;
		logic [TOTAL_W-1:0]   miss_total;
		logic                 sequence_done;
	} out_item_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} lru_state_t;

endpackage

`default_nettype wire

// ===== design/lru_page_replacement.sv =====
`default_nettype none

// lru page replacement list: keeps WAYS resident page numbers in recency order,
// front is most recently used. a request transaction is taken at a clock edge
// where start is high and busy is low; the request is captured, then a parallel
// compare against all valid entries, insertion and move-to-front follows (busy
// high), and the result appears on rsp with done high for exactly one cycle
// right after. the receiver cannot stall, so sample rsp whenever done is high.
// a new request may be started in the same cycle the result is shown, but the
// controller takes none during its update step. hit and miss totals saturate;
// last_in_sequence empties the list and clears the totals once its own result
// is formed.
module lru_page_replacement
	import lru_pkg::*;
#(
	parameter int WAYS      = WAYS_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire in_item_t req,
	output logic          done,
	output out_item_t     rsp
);

	// command bundle from controller to datapath
	dp_cmd_t cmd;

	// controller: capture on start, then the update state
	lru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath: list, valid marks, fill level, totals and result register
	lru_dp #(
		.WAYS      (WAYS),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

`ifndef ASSERT_OFF
	// result strobe never overlaps the update cycle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe during update cycle");

	// an accepted transaction goes straight into the update cycle
	a_accept_to_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not enter update");

	// every update cycle yields exactly one result on the next cycle
	a_busy_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("update cycle without result");
`endif

endmodule

`default_nettype wire

// ===== design/lru_ctrl.sv =====
`default_nettype none

module lru_ctrl
	import lru_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	output dp_cmd_t      cmd
);

	lru_state_t state_q;
	lru_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		busy     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/lru_dp.sv =====
`default_nettype none

module lru_dp
	import lru_pkg::*;
#(
	parameter int WAYS      = WAYS_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire dp_cmd_t  cmd,
	input  wire in_item_t req,
	output logic          done,
	output out_item_t     rsp
);

	localparam int PW = $clog2(WAYS);
	localparam int FW = $clog2(WAYS + 1);

	in_item_t                    req_q;
	logic [WAYS-1:0][PAGE_BITS-1:0] page_q;
	logic [WAYS-1:0]             valid_q;
	logic [FW-1:0]               fill_q;
	logic [TOTAL_W-1:0]          hit_cnt_q;
	logic [TOTAL_W-1:0]          miss_cnt_q;
	logic                        done_q;
	out_item_t                   rsp_q;

	logic [PAGE_ID_W+PAGE_BITS-1:0] ext_w;
	logic [PAGE_BITS-1:0]        page_w;
	logic [WAYS-1:0]             match_w;
	logic                        found_w;
	logic                        full_w;
	logic [PW-1:0]               hit_pos_w;
	logic [PW-1:0]               miss_pos_w;
	logic [PW-1:0]               pos_w;
	logic [PW+SLOT_W-1:0]        pos_ext_w;
	logic [WAYS-1:0][PAGE_BITS-1:0] page_nx;
	logic [WAYS-1:0]             valid_nx;
	logic [FW-1:0]               fill_nx;
	logic [TOTAL_W-1:0]          hit_nx;
	logic [TOTAL_W-1:0]          miss_nx;

	assign ext_w  = {{PAGE_BITS{1'b0}}, req_q.page_id};
	assign page_w = ext_w[PAGE_BITS-1:0];

	// parallel tag compare, highest matching position wins
	always_comb begin
		hit_pos_w = '0;
		for (int i = 0; i < WAYS; i++) begin
			match_w[i] = valid_q[i] && (page_q[i] == page_w);
			if (match_w[i]) begin
				hit_pos_w = PW'(i);
			end
		end
	end

	assign found_w    = |match_w;
	assign full_w     = (fill_q == FW'(WAYS));
	assign miss_pos_w = full_w ? PW'(WAYS - 1) : fill_q[PW-1:0];
	assign pos_w      = found_w ? hit_pos_w : miss_pos_w;
	assign pos_ext_w  = {{SLOT_W{1'b0}}, pos_w};

	// move touched entry to the front, entries ahead of it shift back
	always_comb begin
		page_nx[0]  = page_w;
		valid_nx[0] = 1'b1;
		for (int i = 1; i < WAYS; i++) begin
			if (PW'(i) <= pos_w) begin
				page_nx[i]  = page_q[i-1];
				valid_nx[i] = valid_q[i-1];
			end else begin
				page_nx[i]  = page_q[i];
				valid_nx[i] = valid_q[i];
			end
		end
	end

	assign fill_nx = (found_w || full_w) ? fill_q : fill_q + FW'(1);
	assign hit_nx  = (found_w && hit_cnt_q != TOTAL_MAX) ? hit_cnt_q + TOTAL_W'(1)
		: hit_cnt_q;
	assign miss_nx = (!found_w && miss_cnt_q != TOTAL_MAX) ? miss_cnt_q + TOTAL_W'(1)
		: miss_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			fill_q     <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				if (req_q.last_in_sequence) begin
					valid_q    <= '0;
					fill_q     <= '0;
					hit_cnt_q  <= '0;
					miss_cnt_q <= '0;
				end else begin
					valid_q    <= valid_nx;
					fill_q     <= fill_nx;
					hit_cnt_q  <= hit_nx;
					miss_cnt_q <= miss_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			page_q              <= page_nx;
			rsp_q.hit           <= found_w;
			rsp_q.slot          <= pos_ext_w[SLOT_W-1:0];
			rsp_q.hit_total     <= hit_nx;
			rsp_q.miss_total    <= miss_nx;
			rsp_q.sequence_done <= req_q.last_in_sequence;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// ===== sim/lru_checker.sv =====
`timescale 1ns / 100ps

// watches the request and result channels, keeps its own copy of the lru list
// and checks every result against the oldest outstanding prediction
module lru_checker
	import lru_pkg::*;
#(
	parameter int WAYS      = WAYS_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      busy,
	input  wire in_item_t  req,
	input  wire logic      done,
	input  wire out_item_t rsp,
	output int             pending,
	output int             fail_count
);

	logic [PAGE_BITS-1:0] list_pages [WAYS];
	logic                 list_valid [WAYS];
	int unsigned          list_fill;
	logic [TOTAL_W-1:0]   hit_count;
	logic [TOTAL_W-1:0]   miss_count;
	out_item_t            expected_results [$];
	out_item_t            oldest;

	function automatic void clear_list();
		for (int i = 0; i < WAYS; i++) begin
			list_pages[i] = '0;
			list_valid[i] = 1'b0;
		end
		list_fill  = 0;
		hit_count  = '0;
		miss_count = '0;
	endfunction

	function automatic out_item_t predict_lookup(in_item_t item);
		logic [PAGE_BITS-1:0] page;
		logic [PAGE_BITS-1:0] moved;
		logic                 found;
		int                   pos;
		out_item_t            res;
		page  = PAGE_BITS'(item.page_id);
		found = 1'b0;
		pos   = 0;
		for (int i = 0; i < WAYS; i++) begin
			if (list_valid[i] && list_pages[i] == page) begin
				found = 1'b1;
				pos   = i;
			end
		end
		if (found) begin
			if (hit_count != TOTAL_MAX)
				hit_count++;
		end else begin
			if (miss_count != TOTAL_MAX)
				miss_count++;
			if (list_fill < WAYS) begin
				pos = list_fill;
				list_fill++;
			end else begin
				pos = WAYS - 1;
			end
			list_pages[pos] = page;
			list_valid[pos] = 1'b1;
		end
		// touched entry goes to the front, the ones ahead of it slide back
		moved = list_pages[pos];
		for (int i = pos; i > 0; i--) begin
			list_pages[i] = list_pages[i-1];
			list_valid[i] = list_valid[i-1];
		end
		list_pages[0] = moved;
		list_valid[0] = 1'b1;

		res.hit           = found;
		res.slot          = pos[SLOT_W-1:0];
		res.hit_total     = hit_count;
		res.miss_total    = miss_count;
		res.sequence_done = item.last_in_sequence;
		if (item.last_in_sequence)
			clear_list();
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		$display("lru checker: %s mismatch, expected %0h got %0h at %0t",
			field, want, got, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_list();
			expected_results.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result strobe", 32'd0, 32'd1);
				end else begin
					oldest = expected_results.pop_front();
					if (rsp.hit !== oldest.hit)
						report_mismatch("hit", oldest.hit, rsp.hit);
					if (rsp.slot !== oldest.slot)
						report_mismatch("slot", oldest.slot, rsp.slot);
					if (rsp.hit_total !== oldest.hit_total)
						report_mismatch("hit_total", oldest.hit_total, rsp.hit_total);
					if (rsp.miss_total !== oldest.miss_total)
						report_mismatch("miss_total", oldest.miss_total, rsp.miss_total);
					if (rsp.sequence_done !== oldest.sequence_done)
						report_mismatch("sequence_done", oldest.sequence_done,
							rsp.sequence_done);
				end
			end
			if (start && busy === 1'b0)
				expected_results.push_back(predict_lookup(req));
			pending <= expected_results.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

// stimulus and verdict for the lru page replacement list; all prediction and
// comparison lives in lru_checker
module testbench
	import lru_pkg::*;
;

	// cycles without any accepted request or result before the run is declared hung
	localparam int HANG_LIMIT = 1000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  req;
	logic      done;
	out_item_t rsp;
	int        pending;
	int        fail_count;
	int        idle_cycles = 0;
	int        burst_left;

	// pages that the current sequence keeps coming back to, so hits and
	// evictions both happen often
	logic [PAGE_ID_W-1:0] page_pool [8];
	int                   pool_size;

	lru_page_replacement u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	lru_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any accepted request or result restarts the count
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("** lru_page_replacement: FAILED **");
			$finish;
		end
	end

	// one request transaction: optional idle cycles, then hold start until the
	// block takes it. a zero gap keeps start high straight into the next one
	task automatic send_request(input logic [PAGE_ID_W-1:0] page, input logic last);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 3);
		end
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		req   <= '{page_id: page, last_in_sequence: last};
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// stop sending until every predicted result has come back
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic refill_pool();
		pool_size = $urandom_range(2, 8);
		for (int i = 0; i < 8; i++)
			page_pool[i] = PAGE_ID_W'($urandom());
	endtask

	initial begin
		int                   pick;
		logic [PAGE_ID_W-1:0] page;
		logic                 last;

		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		burst_left = 0;
		refill_pool();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		// page zero on an empty list: cleared slots must not match whatever they still hold
		send_request(16'h0000, 1'b0);
		send_request(16'h0000, 1'b0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'h5555, 1'b0);
		// fourth distinct page fills the list
		send_request(16'hAAAA, 1'b0);
		// hit on the least recently used entry
		send_request(16'h0000, 1'b0);
		// misses on a full list overwrite the last entry; the last request hits
		send_request(16'h1234, 1'b0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'h5555, 1'b0);
		send_request(16'h1234, 1'b0);
		// end of sequence: result still counts, then list and totals clear
		send_request(16'h0000, 1'b1);
		send_request(16'h0000, 1'b0);
		send_request(16'h8001, 1'b0);
		send_request(16'h0000, 1'b0);
		send_request(16'h8001, 1'b1);
		// one request sequence, then the same page again after the clear
		send_request(16'h8001, 1'b1);
		send_request(16'h8001, 1'b0);
		send_request(16'h7FFE, 1'b0);
		send_request(16'hFFFF, 1'b1);
		drain_results();

		// random part: sequences that mostly revisit a small page set
		for (int n = 0; n < 850; n++) begin
			if ($urandom_range(0, 40) == 0)
				burst_left = $urandom_range(10, 30);
			pick = $urandom_range(0, 99);
			if (pick < 78)
				page = page_pool[$urandom_range(0, pool_size - 1)];
			else if (pick < 90)
				page = PAGE_ID_W'($urandom());
			else if (pick < 95)
				page = '0;
			else
				page = '1;
			last = ($urandom_range(0, 15) == 0);
			send_request(page, last);
			if (last)
				refill_pool();
			// hold off midway until the block has gone quiet
			if (n == 425)
				drain_results();
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("** lru_page_replacement: PASSED **");
		else
			$display("** lru_page_replacement: FAILED **");
		$finish;
	end

endmodule
